// File: rtl/core/bwlp_pkg.sv
// ---------------------------------------------------------------------------
// bwlp_pkg: shared definitions for the Butterworth lowpass IIR
// Default widths, register index codes, MAC step codes, history tap layout
// and the configuration write bundle.
// ---------------------------------------------------------------------------
package bwlp_pkg;

	// default parameter values
	localparam int DEF_CHANNELS       = 8;
	localparam int DEF_SAMPLE_BITS    = 24;
	localparam int DEF_COEF_FRAC_BITS = 28;

	// fixed field widths
	localparam int COEF_W     = 32;
	localparam int CH_W       = 3;
	localparam int CFG_IDX_W  = 3;

	// queue depth between front and back, and on the result side
	localparam int QUEUE_DEPTH = 2;

	// accumulator headroom above the sample width
	localparam int ACC_GUARD = 36;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [2:0]           step_t;

	// configuration register indexes
	localparam cfg_idx_t REG_A0 = 3'd0;
	localparam cfg_idx_t REG_A1 = 3'd1;
	localparam cfg_idx_t REG_B1 = 3'd2;
	localparam cfg_idx_t REG_B2 = 3'd3;
	localparam cfg_idx_t REG_B3 = 3'd4;

	// multiply-accumulate steps, one product each
	localparam step_t STEP_A0   = 3'd0;
	localparam step_t STEP_A1   = 3'd1;
	localparam step_t STEP_B1   = 3'd2;
	localparam step_t STEP_B2   = 3'd3;
	localparam step_t STEP_B3   = 3'd4;
	localparam step_t STEP_LAST = STEP_B3;

	// history word layout: three input taps, three output taps
	localparam int HIST_TAPS = 6;
	localparam int TAP_X1 = 0;
	localparam int TAP_X2 = 1;
	localparam int TAP_X3 = 2;
	localparam int TAP_Y1 = 3;
	localparam int TAP_Y2 = 4;
	localparam int TAP_Y3 = 5;

	// one configuration write beat
	typedef struct packed {
		logic              we;
		cfg_idx_t          index;
		logic [COEF_W-1:0] data;
	} cfg_wr_t;

endpackage

// File: rtl/core/butterworth3_lowpass_iir.sv
// ---------------------------------------------------------------------------
// butterworth3_lowpass_iir: multi-channel third-order lowpass, direct form I
// Symmetric-numerator IIR with per-channel history; Q4.28 coefficients.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive sample_in/channel_sel and raise push; the beat is taken
//   on a clock edge where full is low. Results come out as a queue: while
//   empty is low, sample_out/channel_out hold the oldest result, taken on an
//   edge with pop high. Results leave in input order, one per input beat.
//   Coefficients are written through cfg_we/cfg_index/cfg_data (index 0..4:
//   a0, a1, b1, b2, b3; other indexes ignored) while the filter is idle.
//   The engine handles one beat at a time: the history read, five products
//   through the single shared multiplier and its two-stage multiply pipeline,
//   then the round/write-back step. A beat for a channel at or above CHANNELS
//   skips the multiplier, gives zero and leaves history alone.
//   A two-entry command queue lets inputs be taken while the engine works;
//   a two-entry result queue lets the engine finish while pop is held low.
//   When both queues fill, full rises and stays high until pop resumes.
//   Reset clears coefficients to zero, empties both queues and marks every
//   channel's history as zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
module butterworth3_lowpass_iir #(
	parameter int CHANNELS       = bwlp_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS    = bwlp_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = bwlp_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bwlp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bwlp_pkg::COEF_W-1:0]        cfg_data,
	input  logic                               push,
	output logic                               full,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	input  logic [bwlp_pkg::CH_W-1:0]          channel_sel,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic [bwlp_pkg::CH_W-1:0]          channel_out
);

	localparam int CMD_W = SAMPLE_BITS + bwlp_pkg::CH_W + 1;
	localparam int RES_W = SAMPLE_BITS + bwlp_pkg::CH_W;

	bwlp_pkg::cfg_wr_t cfg;
	logic              cmd_empty;
	logic              cmd_pop;
	logic [CMD_W-1:0]  cmd_data;
	logic              res_full;
	logic              res_push;
	logic [RES_W-1:0]  res_data;
	logic [RES_W-1:0]  res_head;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// accept and classify input beats
	bwlp_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_in   (sample_in),
		.channel_sel (channel_sel),
		.cmd_pop     (cmd_pop),
		.cmd_empty   (cmd_empty),
		.cmd_data    (cmd_data)
	);

	// filter engine
	bwlp_back #(
		.CHANNELS       (CHANNELS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_data  (cmd_data),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// result queue
	bwlp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (bwlp_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign sample_out  = res_head[SAMPLE_BITS-1:0];
	assign channel_out = res_head[RES_W-1:SAMPLE_BITS];

`ifndef SYNTH
	// engine never retires into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while result queue full");

	// engine only takes a command that is present
	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");

	// a channel outside the filter bank always reads back as zero
	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (32'(channel_out) >= CHANNELS)) |-> (sample_out == '0))
		else $error("nonzero result for nonexistent channel");

	// a command taken into the engine is not followed by another on the next edge
	a_min_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !cmd_pop)
		else $error("engine took two commands back to back");
`endif

endmodule

// File: rtl/core/bwlp_fifo.sv
// ---------------------------------------------------------------------------
// bwlp_fifo: small register queue
// Push/pop queue with full and empty flags; head entry shown on rd_data.
// ---------------------------------------------------------------------------
module bwlp_fifo #(
	parameter int WIDTH = bwlp_pkg::DEF_SAMPLE_BITS,
	parameter int DEPTH = bwlp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/core/bwlp_front.sv
// ---------------------------------------------------------------------------
// bwlp_front: input side of the lowpass filter
// Takes sample beats, tags each with whether its channel exists, and queues
// them as commands for the back end.
// ---------------------------------------------------------------------------
module bwlp_front #(
	parameter int CHANNELS    = bwlp_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = bwlp_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [bwlp_pkg::CH_W-1:0]     channel_sel,
	input  logic                          cmd_pop,
	output logic                          cmd_empty,
	output logic [SAMPLE_BITS+bwlp_pkg::CH_W:0] cmd_data
);

	localparam int CMD_W = SAMPLE_BITS + bwlp_pkg::CH_W + 1;

	logic             ch_ok;
	logic [CMD_W-1:0] cmd_in;

	// channels beyond the configured count bypass the filter and give zero
	assign ch_ok  = (32'(channel_sel) < CHANNELS);
	assign cmd_in = {ch_ok, channel_sel, sample_in};

	bwlp_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (bwlp_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cmd_in),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (cmd_data),
		.empty   (cmd_empty)
	);

endmodule

// File: rtl/core/bwlp_back.sv
// ---------------------------------------------------------------------------
// bwlp_back: filter engine
// Holds the coefficients and per-channel history, runs the five products
// through one shared multiplier, rounds and saturates, updates history.
// ---------------------------------------------------------------------------
module bwlp_back #(
	parameter int CHANNELS       = bwlp_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS    = bwlp_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = bwlp_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bwlp_pkg::cfg_wr_t                   cfg,
	input  logic                                cmd_empty,
	output logic                                cmd_pop,
	input  logic [SAMPLE_BITS+bwlp_pkg::CH_W:0] cmd_data,
	input  logic                                res_full,
	output logic                                res_push,
	output logic [SAMPLE_BITS+bwlp_pkg::CH_W-1:0] res_data
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int OPND_W   = SAMPLE_BITS + 1;
	localparam int PROD_W   = OPND_W + bwlp_pkg::COEF_W;
	localparam int ACC_W    = SAMPLE_BITS + bwlp_pkg::ACC_GUARD;
	localparam int CW       = bwlp_pkg::COEF_W;
	localparam int CHW      = bwlp_pkg::CH_W;

	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	typedef logic [bwlp_pkg::HIST_TAPS-1:0][SAMPLE_BITS-1:0] hist_t;

	// coefficient registers
	logic signed [CW-1:0] coef_a0_q, coef_a1_q, coef_b1_q, coef_b2_q, coef_b3_q;

	// history store with one valid bit per channel
	hist_t               hist_mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	hist_t               hist_rd_q;
	logic                vld_rd_q;
	hist_t               hist_cur;
	hist_t               hist_new;
	logic                hist_we;

	// command fields
	logic signed [SAMPLE_BITS-1:0] cmd_sample;
	logic [CHW-1:0]                cmd_ch;
	logic                          cmd_ok;
	logic [CH_IDX_W-1:0]           cmd_addr;

	// per-item registers
	logic [1:0]                    state_q;
	bwlp_pkg::step_t               step_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [CHW-1:0]                ch_q;
	logic                          ok_q;
	logic [CH_IDX_W-1:0]           addr_q;
	logic signed [ACC_W-1:0]       acc_q;

	// multiplier pipeline
	logic                     v_s1, v_s2;
	logic signed [OPND_W-1:0] opnd_s1;
	logic signed [CW-1:0]     coef_s1;
	logic                     neg_s1, neg_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [OPND_W-1:0] opnd;
	logic signed [CW-1:0]     coef_sel;
	logic                     neg;

	// rounding
	logic signed [ACC_W-1:0]       acc_rnd;
	logic signed [ACC_W-1:0]       acc_shf;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [SAMPLE_BITS-1:0] y_out;

	assign cmd_sample = cmd_data[SAMPLE_BITS-1:0];
	assign cmd_ch     = cmd_data[SAMPLE_BITS+CHW-1:SAMPLE_BITS];
	assign cmd_ok     = cmd_data[SAMPLE_BITS+CHW];
	assign cmd_addr   = CH_IDX_W'(cmd_ch);

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign res_push = (state_q == ST_FIN) && !res_full;
	assign hist_we  = res_push && ok_q;

	// coefficient writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a0_q <= '0;
			coef_a1_q <= '0;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_b3_q <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				bwlp_pkg::REG_A0: coef_a0_q <= cfg.data;
				bwlp_pkg::REG_A1: coef_a1_q <= cfg.data;
				bwlp_pkg::REG_B1: coef_b1_q <= cfg.data;
				bwlp_pkg::REG_B2: coef_b2_q <= cfg.data;
				bwlp_pkg::REG_B3: coef_b3_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// history memory: read when a command is taken, written when it retires
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[addr_q] <= hist_new;
		end
		if (cmd_pop) begin
			hist_rd_q <= hist_mem[cmd_addr];
		end
	end

	// valid bits stand in for clearing the history at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (hist_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (cmd_pop) begin
				vld_rd_q <= valid_q[cmd_addr];
			end
		end
	end

	assign hist_cur = vld_rd_q ? hist_rd_q : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= bwlp_pkg::STEP_A0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					step_q <= bwlp_pkg::STEP_A0;
					if (!cmd_empty) begin
						state_q <= cmd_ok ? ST_MAC : ST_FIN;
					end
				end
				ST_MAC: begin
					if (step_q == bwlp_pkg::STEP_LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last product is being summed this cycle
					if (v_s2 && !v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand and coefficient for the current step
	always_comb begin
		opnd     = '0;
		coef_sel = '0;
		neg      = 1'b0;
		case (step_q)
			bwlp_pkg::STEP_A0: begin
				opnd     = OPND_W'(x_q) + OPND_W'($signed(hist_cur[bwlp_pkg::TAP_X3]));
				coef_sel = coef_a0_q;
			end
			bwlp_pkg::STEP_A1: begin
				opnd     = OPND_W'($signed(hist_cur[bwlp_pkg::TAP_X1]))
					+ OPND_W'($signed(hist_cur[bwlp_pkg::TAP_X2]));
				coef_sel = coef_a1_q;
			end
			bwlp_pkg::STEP_B1: begin
				opnd     = OPND_W'($signed(hist_cur[bwlp_pkg::TAP_Y1]));
				coef_sel = coef_b1_q;
				neg      = 1'b1;
			end
			bwlp_pkg::STEP_B2: begin
				opnd     = OPND_W'($signed(hist_cur[bwlp_pkg::TAP_Y2]));
				coef_sel = coef_b2_q;
				neg      = 1'b1;
			end
			bwlp_pkg::STEP_B3: begin
				opnd     = OPND_W'($signed(hist_cur[bwlp_pkg::TAP_Y3]));
				coef_sel = coef_b3_q;
				neg      = 1'b1;
			end
			default: ;
		endcase
	end

	// operand register, multiply, accumulate
	always_ff @(posedge clk) begin
		opnd_s1 <= opnd;
		coef_s1 <= coef_sel;
		neg_s1  <= neg;
		prod_s2 <= PROD_W'(opnd_s1) * PROD_W'(coef_s1);
		neg_s2  <= neg_s1;
		if (cmd_pop) begin
			x_q    <= cmd_sample;
			ch_q   <= cmd_ch;
			ok_q   <= cmd_ok;
			addr_q <= cmd_addr;
			acc_q  <= '0;
		end else if (v_s2) begin
			if (neg_s2) begin
				acc_q <= acc_q - ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// round half up, drop fraction bits, clamp to sample range
	assign acc_rnd = acc_q + HALF_LSB;
	assign acc_shf = acc_rnd >>> COEF_FRAC_BITS;

	always_comb begin
		if (acc_shf > Y_MAX) begin
			y_sat = Y_MAX[SAMPLE_BITS-1:0];
		end else if (acc_shf < Y_MIN) begin
			y_sat = Y_MIN[SAMPLE_BITS-1:0];
		end else begin
			y_sat = acc_shf[SAMPLE_BITS-1:0];
		end
	end

	assign y_out = ok_q ? y_sat : '0;

	// shifted history for write-back
	always_comb begin
		hist_new                     = hist_cur;
		hist_new[bwlp_pkg::TAP_X1]   = x_q;
		hist_new[bwlp_pkg::TAP_X2]   = hist_cur[bwlp_pkg::TAP_X1];
		hist_new[bwlp_pkg::TAP_X3]   = hist_cur[bwlp_pkg::TAP_X2];
		hist_new[bwlp_pkg::TAP_Y1]   = y_sat;
		hist_new[bwlp_pkg::TAP_Y2]   = hist_cur[bwlp_pkg::TAP_Y1];
		hist_new[bwlp_pkg::TAP_Y3]   = hist_cur[bwlp_pkg::TAP_Y2];
	end

	assign res_data = {ch_q, y_out};

endmodule

// File: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the third-order Butterworth lowpass IIR
// Sample beats are pushed in random bursts and checked against a bit-exact
// fixed-point predictor of the filter: per-channel history, exact sum,
// round half up, saturation. Coefficients change between idle phases.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int NCH   = bwlp_pkg::DEF_CHANNELS;
	localparam int SBITS = bwlp_pkg::DEF_SAMPLE_BITS;
	localparam int FRAC  = bwlp_pkg::DEF_COEF_FRAC_BITS;
	localparam int ACC_W = 96;

	localparam int SETTLE_CYCLES = 16;   // block latency plus margin
	localparam int LIMIT_CYCLES  = 200_000;
	localparam int RANDOM_SETS   = 10;
	localparam int SET_BEATS     = 50;
	localparam int HOLD_CYCLES   = 250;
	localparam int MAX_HOLDS     = 3;

	localparam logic signed [SBITS-1:0] SMP_MAX = SBITS'((1 << (SBITS - 1)) - 1);
	localparam logic signed [SBITS-1:0] SMP_MIN = SBITS'(1 << (SBITS - 1));

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(SMP_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(SMP_MIN);

	// Q4.28 gains
	localparam logic signed [bwlp_pkg::COEF_W-1:0] GAIN_ZERO = 32'sh0000_0000;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] GAIN_HALF = 32'sh0800_0000;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] GAIN_ONE  = 32'sh1000_0000;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] GAIN_MAX  = 32'sh7fff_ffff;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] GAIN_MIN  = 32'sh8000_0000;

	// realistic design, cutoff near a tenth of the sample rate
	localparam logic signed [bwlp_pkg::COEF_W-1:0] BW_A0 = 32'sd4858395;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] BW_A1 = 32'sd14575177;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] BW_B1 = -32'sd472457649;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] BW_B2 = 32'sd317530491;
	localparam logic signed [bwlp_pkg::COEF_W-1:0] BW_B3 = -32'sd74641141;

	typedef struct packed {
		logic signed [SBITS-1:0]   sample;
		logic [bwlp_pkg::CH_W-1:0] channel;
	} beat_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic [bwlp_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
	logic [bwlp_pkg::COEF_W-1:0]    cfg_data    = '0;
	logic                           push        = 1'b0;
	logic                           full;
	logic signed [SBITS-1:0]        sample_in   = '0;
	logic [bwlp_pkg::CH_W-1:0]      channel_sel = '0;
	logic                           empty;
	logic                           pop         = 1'b0;
	logic signed [SBITS-1:0]        sample_out;
	logic [bwlp_pkg::CH_W-1:0]      channel_out;

	// beats waiting to be sent, and filtered beats waiting to come out
	beat_t sample_q[$];
	beat_t filtered_q[$];

	// predictor state: gains and per-channel history
	logic signed [bwlp_pkg::COEF_W-1:0] gain [0:4];
	logic signed [SBITS-1:0]  xh1 [NCH];
	logic signed [SBITS-1:0]  xh2 [NCH];
	logic signed [SBITS-1:0]  xh3 [NCH];
	logic signed [SBITS-1:0]  yh1 [NCH];
	logic signed [SBITS-1:0]  yh2 [NCH];
	logic signed [SBITS-1:0]  yh3 [NCH];

	int unsigned beats_in     = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned gain_sets    = 0;
	int unsigned holds_done   = 0;
	int unsigned cycle_count  = 0;

	butterworth3_lowpass_iir #(
		.CHANNELS       (NCH),
		.SAMPLE_BITS    (SBITS),
		.COEF_FRAC_BITS (FRAC)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.sample_in   (sample_in),
		.channel_sel (channel_sel),
		.empty       (empty),
		.pop         (pop),
		.sample_out  (sample_out),
		.channel_out (channel_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one filter step: exact sum, round half up, clamp, then shift history
	// (a 3-bit channel code is always a valid channel here)
	function automatic logic signed [SBITS-1:0] filter_sample(
		input logic signed [SBITS-1:0]   x,
		input logic [bwlp_pkg::CH_W-1:0] ch
	);
		logic signed [ACC_W-1:0] acc;
		logic signed [SBITS-1:0] y;
		acc = ACC_W'(gain[bwlp_pkg::REG_A0]) * (ACC_W'(x) + ACC_W'(xh3[ch]))
			+ ACC_W'(gain[bwlp_pkg::REG_A1]) * (ACC_W'(xh1[ch]) + ACC_W'(xh2[ch]))
			- ACC_W'(gain[bwlp_pkg::REG_B1]) * ACC_W'(yh1[ch])
			- ACC_W'(gain[bwlp_pkg::REG_B2]) * ACC_W'(yh2[ch])
			- ACC_W'(gain[bwlp_pkg::REG_B3]) * ACC_W'(yh3[ch]);
		acc = (acc + ROUND_BIAS) >>> FRAC;
		if (acc > SAT_HI)
			acc = SAT_HI;
		else if (acc < SAT_LO)
			acc = SAT_LO;
		y = acc[SBITS-1:0];
		xh3[ch] = xh2[ch];
		xh2[ch] = xh1[ch];
		xh1[ch] = x;
		yh3[ch] = yh2[ch];
		yh2[ch] = yh1[ch];
		yh1[ch] = y;
		return y;
	endfunction

	task automatic write_reg(
		input bwlp_pkg::cfg_idx_t                 idx,
		input logic signed [bwlp_pkg::COEF_W-1:0] val
	);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx <= bwlp_pkg::REG_B3)
			gain[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// load all five gains, plus one write to an unused index
	task automatic set_gains(
		input logic signed [bwlp_pkg::COEF_W-1:0] a0, a1, b1, b2, b3
	);
		write_reg(bwlp_pkg::REG_A0, a0);
		write_reg(bwlp_pkg::REG_A1, a1);
		write_reg(bwlp_pkg::REG_B1, b1);
		write_reg(bwlp_pkg::REG_B2, b2);
		write_reg(bwlp_pkg::REG_B3, b3);
		write_reg(bwlp_pkg::cfg_idx_t'($urandom_range(int'(bwlp_pkg::REG_B3) + 1,
			(1 << bwlp_pkg::CFG_IDX_W) - 1)), bwlp_pkg::COEF_W'($urandom));
		gain_sets++;
	endtask

	task automatic queue_beat(
		input logic signed [SBITS-1:0]   x,
		input logic [bwlp_pkg::CH_W-1:0] ch
	);
		beat_t b;
		b.sample  = x;
		b.channel = ch;
		sample_q.push_back(b);
	endtask

	// wait until every beat is sent and filtered, then let the engine drain
	task automatic settle();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || push || filtered_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic flag(input string field, input int want, input int got);
		mismatches++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// driver: bursts of beats with random gaps; holds a beat while full
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_beats
		beat_t nxt;
		logic  next_push;
		if (arst_n) begin
			if (push && !full) begin
				nxt.sample  = filter_sample(sample_in, channel_sel);
				nxt.channel = channel_sel;
				filtered_q.push_back(nxt);
				beats_in++;
			end
			next_push = push && full;
			if (!next_push) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_q.size() > 0) begin
					nxt = sample_q.pop_front();
					sample_in   <= nxt.sample;
					channel_sel <= nxt.channel;
					next_push = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			push <= next_push;
		end
	end

	// monitor: checks each result beat, pops on a random stall pattern
	int          hold_left    = 0;
	int unsigned next_hold_at = 40;
	logic [31:0] stall_pat    = '1;
	int          pat_left     = 0;

	always @(posedge clk) begin : take_results
		beat_t want;
		logic  next_pop;
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (filtered_q.size() == 0) begin
					flag("unexpected result, sample_out", 0, int'(sample_out));
				end else begin
					want = filtered_q.pop_front();
					if (sample_out !== want.sample)
						flag("sample_out", int'(want.sample), int'(sample_out));
					if (channel_out !== want.channel)
						flag("channel_out", int'(want.channel), int'(channel_out));
				end
			end
			// long hold-off while the sender still has plenty to offer
			if (hold_left == 0 && holds_done < MAX_HOLDS && results_seen >= next_hold_at
					&& sample_q.size() >= 16) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				next_hold_at += 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_pop = 1'b0;
			end else begin
				if (pat_left == 0) begin
					stall_pat = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
					pat_left  = 32;
				end
				next_pop  = stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[31:1]};
				pat_left--;
			end
			pop <= next_pop;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("** butterworth3_lowpass_iir: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		logic signed [bwlp_pkg::COEF_W-1:0] g [5];
		logic signed [SBITS-1:0]            last_x [NCH];
		logic signed [SBITS-1:0]            x;
		logic [bwlp_pkg::CH_W-1:0]          ch;
		for (int i = 0; i <= int'(bwlp_pkg::REG_B3); i++)
			gain[i] = GAIN_ZERO;
		for (int c = 0; c < NCH; c++) begin
			xh1[c] = '0; xh2[c] = '0; xh3[c] = '0;
			yh1[c] = '0; yh2[c] = '0; yh3[c] = '0;
			last_x[c] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// gains at reset: output stays zero, history still moves
		queue_beat(SMP_MAX, 0);
		queue_beat(SMP_MIN, 7);
		queue_beat('0, 3);
		settle();

		// half gain on x and x3 only: halves round toward +inf
		set_gains(GAIN_HALF, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
		queue_beat(1, 1);
		queue_beat(-1, 2);
		queue_beat(-3, 2);
		queue_beat(SMP_MAX, 4);
		for (int i = 0; i < 4; i++)
			queue_beat(SMP_MIN, 4);
		settle();

		// extreme gains: saturation at both ends
		set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		queue_beat(SMP_MAX, 6);
		queue_beat(SMP_MIN, 6);
		queue_beat(-1, 6);
		settle();
		set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
		queue_beat(SMP_MAX, 5);
		queue_beat(SMP_MIN, 5);
		queue_beat('0, 5);
		settle();

		// random part: rotate through gain styles, history carries over
		for (int s = 0; s < RANDOM_SETS; s++) begin
			for (int i = 0; i < 5; i++) begin
				case (s % 4)
					1: g[i] = $signed(bwlp_pkg::COEF_W'($urandom_range(0, 32'h1fff_ffff)))
						- GAIN_ONE;
					2: g[i] = $signed(bwlp_pkg::COEF_W'($urandom));
					3: begin
						case ($urandom_range(0, 5))
							0: g[i] = GAIN_ZERO;
							1: g[i] = GAIN_MAX;
							2: g[i] = GAIN_MIN;
							3: g[i] = GAIN_ONE;
							4: g[i] = -GAIN_ONE;
							default: g[i] = $signed(bwlp_pkg::COEF_W'($urandom));
						endcase
					end
					default: g[i] = GAIN_ZERO;
				endcase
			end
			if (s % 4 == 0)
				set_gains(BW_A0, BW_A1, BW_B1, BW_B2, BW_B3);
			else
				set_gains(g[0], g[1], g[2], g[3], g[4]);
			for (int n = 0; n < SET_BEATS; n++) begin
				ch = bwlp_pkg::CH_W'($urandom_range(0, NCH - 1));
				case ($urandom_range(0, 9))
					5, 6: x = SBITS'(int'($urandom_range(0, 8191)) - 4096);
					7: x = SMP_MAX;
					8: x = SMP_MIN;
					9: x = last_x[ch];
					default: x = SBITS'($urandom);
				endcase
				last_x[ch] = x;
				queue_beat(x, ch);
			end
			settle();
		end

		$display("Filtered %0d sample beats on %0d channels under %0d gain sets.",
			beats_in, NCH, gain_sets);
		$display("Checked %0d result beats; %0d long receiver holds; %0d mismatches.",
			results_seen, holds_done, mismatches);
		if (mismatches == 0)
			$display("** butterworth3_lowpass_iir: PASSED **");
		else
			$display("** butterworth3_lowpass_iir: FAILED **");
		$finish;
	end

endmodule

// File: butterworth3_lowpass_iir.f
rtl/core/bwlp_pkg.sv
rtl/core/bwlp_fifo.sv
rtl/core/bwlp_front.sv
rtl/core/bwlp_back.sv
rtl/core/butterworth3_lowpass_iir.sv
tb/tb_top.sv
